[rtl/core/tdetc_pkg.sv]
// trade date and event time check: shared types, constants and calendar tables
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tdetc_pkg;

  localparam logic [31:0] DATE_LIMIT   = 32'd22010000;
  localparam logic [26:0] YEAR_RECIP   = 27'd109951163;
  localparam int          YEAR_SHIFT   = 40;
  localparam logic [13:0] HUND_RECIP   = 14'd10486;
  localparam int          HUND_SHIFT   = 20;
  localparam logic [13:0] TEN_THOUSAND = 14'd10000;
  localparam logic [6:0]  HUNDRED      = 7'd100;

  localparam logic [11:0] YEAR_MIN      = 12'd1992;
  localparam logic [11:0] YEAR_NOLEAP_A = 12'd2100;
  localparam logic [11:0] YEAR_NOLEAP_B = 12'd2200;
  localparam logic [11:0] ERA_SPLIT     = 12'd2000;
  localparam logic [11:0] ERA_LO_BASE   = 12'd1600;
  localparam logic [17:0] ERA_HI_ADJ    = 18'd11017;
  localparam logic [17:0] ERA_LO_ADJ    = 18'd135080;

  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [63:0] NS_PER_DAY  = 64'd86400000000000;

  localparam logic signed [16:0] ZONE_OFFSET_RESET = 17'sd28800;

  typedef struct packed {
    logic [31:0]        date_digits;
    logic               time_present;
    logic [63:0]        ns_since_midnight;
    logic signed [63:0] event_unix_ns;
  } tdetc_in_t;

  typedef struct packed {
    logic        date_ok;
    logic [16:0] epoch_days;
    logic        time_consistent;
  } tdetc_out_t;

  typedef struct packed {
    logic        present;
    logic        zero_ok;
    logic        ns_ok;
    logic [63:0] target;
  } tdetc_side_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } tdetc_date_t;

  typedef struct packed {
    logic        ok;
    logic [16:0] days;
  } tdetc_days_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the month, year starting in march
  function automatic logic [8:0] march_cum(input logic [3:0] am);
    logic [8:0] c;
    unique case (am)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd61;
      4'd3:    c = 9'd92;
      4'd4:    c = 9'd122;
      4'd5:    c = 9'd153;
      4'd6:    c = 9'd184;
      4'd7:    c = 9'd214;
      4'd8:    c = 9'd245;
      4'd9:    c = 9'd275;
      4'd10:   c = 9'd306;
      4'd11:   c = 9'd337;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/tdetc_date_split.sv]
// date digit split and calendar check, four pipeline stages
// depends on tdetc_pkg; also prepares the time side fields
`timescale 1ns / 1ps

module tdetc_date_split (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  tdetc_pkg::tdetc_in_t   in_item,
  output logic                   out_v,
  output tdetc_pkg::tdetc_date_t out_date,
  output tdetc_pkg::tdetc_side_t out_side
);
  import tdetc_pkg::*;

  logic [24:0] d_lo;
  logic [51:0] yprod;
  tdetc_side_t side_nxt;

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic        s1_bad_r;
  logic [11:0] s1_year_r, s2_year_r, s3_year_r;
  logic [24:0] s1_dlo_r;
  tdetc_side_t s1_side_r, s2_side_r, s3_side_r, s4_side_r;

  logic [25:0] ykilo;
  logic [25:0] rem_w;
  logic [13:0] s2_rem_r, s3_rem_r;
  logic        s2_yok_r, s3_yok_r;

  logic [27:0] mprod;
  logic [6:0]  s3_mon_r;

  logic [13:0] mhund;
  logic [13:0] dd_w;
  logic [6:0]  dd;
  logic        leap;
  logic [4:0]  lim;
  logic        ok_nxt;
  tdetc_date_t s4_date_r;

  assign d_lo  = in_item.date_digits[24:0];
  assign yprod = d_lo * YEAR_RECIP;

  assign side_nxt.present = in_item.time_present;
  assign side_nxt.zero_ok = (in_item.ns_since_midnight == 64'd0) &&
                            (in_item.event_unix_ns == 64'sd0);
  assign side_nxt.ns_ok   = in_item.ns_since_midnight < NS_PER_DAY;
  assign side_nxt.target  = in_item.event_unix_ns - in_item.ns_since_midnight;

  assign ykilo = s1_year_r * TEN_THOUSAND;
  assign rem_w = {1'b0, s1_dlo_r} - ykilo;

  assign mprod = s2_rem_r * HUND_RECIP;

  assign mhund  = s3_mon_r * HUNDRED;
  assign dd_w   = s3_rem_r - mhund;
  assign dd     = dd_w[6:0];
  assign leap   = (s3_year_r[1:0] == 2'd0) && (s3_year_r != YEAR_NOLEAP_A) &&
                  (s3_year_r != YEAR_NOLEAP_B);
  assign lim    = month_len(s3_mon_r[3:0], leap);
  assign ok_nxt = s3_yok_r && (s3_mon_r >= 7'd1) && (s3_mon_r <= 7'd12) &&
                  (dd != 7'd0) && (dd <= {2'b00, lim});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bad_r  <= in_item.date_digits >= DATE_LIMIT;
      s1_year_r <= yprod[YEAR_SHIFT+11:YEAR_SHIFT];
      s1_dlo_r  <= d_lo;
      s1_side_r <= side_nxt;

      s2_year_r <= s1_year_r;
      s2_rem_r  <= rem_w[13:0];
      s2_yok_r  <= !s1_bad_r && (s1_year_r >= YEAR_MIN);
      s2_side_r <= s1_side_r;

      s3_year_r <= s2_year_r;
      s3_rem_r  <= s2_rem_r;
      s3_yok_r  <= s2_yok_r;
      s3_mon_r  <= mprod[HUND_SHIFT+6:HUND_SHIFT];
      s3_side_r <= s2_side_r;

      s4_date_r.ok    <= ok_nxt;
      s4_date_r.year  <= s3_year_r;
      s4_date_r.month <= s3_mon_r[3:0];
      s4_date_r.day   <= dd[4:0];
      s4_side_r       <= s3_side_r;
    end
  end

  assign out_v    = s4_v_r;
  assign out_date = s4_date_r;
  assign out_side = s4_side_r;

  a_date_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s4_date_r.ok) |-> (s4_date_r.month >= 4'd1 && s4_date_r.month <= 4'd12 &&
                                  s4_date_r.day != 5'd0 && s4_date_r.year >= YEAR_MIN &&
                                  s4_date_r.year <= YEAR_NOLEAP_B))
    else $error("accepted date has fields out of range");

endmodule

[rtl/core/tdetc_civil_days.sv]
// days from civil date to days since 1970-01-01, two pipeline stages
// depends on tdetc_pkg; fed by tdetc_date_split
`timescale 1ns / 1ps

module tdetc_civil_days (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  tdetc_pkg::tdetc_date_t in_date,
  input  tdetc_pkg::tdetc_side_t in_side,
  output logic                   out_v,
  output tdetc_pkg::tdetc_days_t out_days,
  output tdetc_pkg::tdetc_side_t out_side
);
  import tdetc_pkg::*;

  logic [11:0] ay;
  logic        era_hi;
  logic [11:0] yoe_w;
  logic [3:0]  am;
  logic [8:0]  doy;

  logic        s5_v_r, s6_v_r;
  logic        s5_ok_r;
  logic        s5_era_r;
  logic [8:0]  s5_yoe_r;
  logic [8:0]  s5_doy_r;
  tdetc_side_t s5_side_r, s6_side_r;

  logic [1:0]  ycent;
  logic [17:0] doe;
  logic [17:0] days_w;
  tdetc_days_t s6_days_r;

  assign ay     = in_date.year - {11'd0, (in_date.month <= 4'd2)};
  assign era_hi = ay >= ERA_SPLIT;
  assign yoe_w  = ay - (era_hi ? ERA_SPLIT : ERA_LO_BASE);
  assign am     = (in_date.month > 4'd2) ? in_date.month - 4'd3 : in_date.month + 4'd9;
  assign doy    = march_cum(am) + {4'd0, in_date.day} - 9'd1;

  always_comb begin
    priority if (s5_yoe_r >= 9'd300) ycent = 2'd3;
    else if (s5_yoe_r >= 9'd200)     ycent = 2'd2;
    else if (s5_yoe_r >= 9'd100)     ycent = 2'd1;
    else                             ycent = 2'd0;
  end

  assign doe    = 18'(s5_yoe_r) * 18'd365 + 18'(s5_yoe_r[8:2]) - 18'(ycent) +
                  18'(s5_doy_r);
  assign days_w = s5_era_r ? doe + ERA_HI_ADJ : doe - ERA_LO_ADJ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= in_v;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ok_r   <= in_date.ok;
      s5_era_r  <= era_hi;
      s5_yoe_r  <= yoe_w[8:0];
      s5_doy_r  <= doy;
      s5_side_r <= in_side;

      s6_days_r.ok   <= s5_ok_r;
      s6_days_r.days <= s5_ok_r ? days_w[16:0] : 17'd0;
      s6_side_r      <= s5_side_r;
    end
  end

  assign out_v    = s6_v_r;
  assign out_days = s6_days_r;
  assign out_side = s6_side_r;

  a_days_span : assert property (@(posedge clk) disable iff (!rst_n)
    (s6_v_r && s6_days_r.ok) |-> (s6_days_r.days >= 17'd8035 && s6_days_r.days <= 17'd84737))
    else $error("day count of a valid date out of span");

endmodule

[rtl/core/tdetc_time_check.sv]
// expected event time from day count and zone offset, compare, output register
// depends on tdetc_pkg; fed by tdetc_civil_days
`timescale 1ns / 1ps

module tdetc_time_check (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  tdetc_pkg::tdetc_days_t in_days,
  input  tdetc_pkg::tdetc_side_t in_side,
  input  logic signed [16:0]     zone_off,
  output logic                   out_v,
  output tdetc_pkg::tdetc_out_t  out_item
);
  import tdetc_pkg::*;

  logic [33:0]        dprod;
  logic [34:0]        secs;
  logic               s7_v_r, s8_v_r, s9_v_r;
  logic [34:0]        s7_secs_r;
  tdetc_days_t        s7_days_r, s8_days_r;
  tdetc_side_t        s7_side_r, s8_side_r;

  logic [46:0]        plo;
  logic signed [48:0] phi;
  logic [46:0]        s8_plo_r;
  logic signed [48:0] s8_phi_r;

  logic [63:0]        expect_ns;
  logic               cons;
  tdetc_out_t         s9_item_r;

  assign dprod = in_days.days * SEC_PER_DAY;
  assign secs  = {1'b0, dprod} - {{18{zone_off[16]}}, zone_off};

  assign plo = s7_secs_r[16:0] * NS_PER_SEC;
  assign phi = $signed(s7_secs_r[34:17]) * $signed({1'b0, NS_PER_SEC});

  assign expect_ns = 64'(s8_plo_r) + {s8_phi_r[46:0], 17'd0};
  assign cons      = s8_side_r.present ?
                     (s8_side_r.ns_ok && s8_days_r.ok && (expect_ns == s8_side_r.target)) :
                     s8_side_r.zero_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= in_v;
      s8_v_r <= s7_v_r;
      s9_v_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_secs_r <= secs;
      s7_days_r <= in_days;
      s7_side_r <= in_side;

      s8_plo_r  <= plo;
      s8_phi_r  <= phi;
      s8_days_r <= s7_days_r;
      s8_side_r <= s7_side_r;

      s9_item_r.date_ok         <= s8_days_r.ok;
      s9_item_r.epoch_days      <= s8_days_r.days;
      s9_item_r.time_consistent <= cons;
    end
  end

  assign out_v    = s9_v_r;
  assign out_item = s9_item_r;

  a_days_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (s9_v_r && !s9_item_r.date_ok) |-> (s9_item_r.epoch_days == 17'd0))
    else $error("invalid date carries a day count");

  a_timed_needs_date : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s8_v_r && s8_side_r.present && !s8_days_r.ok) |=>
      (s9_v_r && !s9_item_r.time_consistent))
    else $error("timed record marked consistent without a valid date");

endmodule

[rtl/core/trade_date_event_time_check.sv]
// top level of the trade date and event time check
// depends on tdetc_pkg, tdetc_date_split, tdetc_civil_days, tdetc_time_check
//
//   channel   direction  ports                          transfer when
//   in        input      in_valid in_ready in_item      in_valid && in_ready
//   out       output     out_valid out_ready out_item   out_valid && out_ready
//   cfg       input      cfg_wr_en cfg_wr_data          cfg_wr_en
//
// nine register stages, one transfer per cycle unless out_ready stalls; output
// valid follows an input transfer through them; the last is the output register
// the pipeline moves as one: it advances when the output register is empty or taken
// reset clears every stage valid bit and loads the zone offset with 28800
// a stall on out_ready freezes all stages, so in_ready drops in the same cycle
`timescale 1ns / 1ps

module trade_date_event_time_check (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tdetc_pkg::tdetc_in_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tdetc_pkg::tdetc_out_t out_item,
  input  logic                  cfg_wr_en,
  input  logic signed [16:0]    cfg_wr_data
);
  import tdetc_pkg::*;

  logic signed [16:0] zone_off_r;
  logic               adv;

  logic               date_v;
  tdetc_date_t        date_q;
  tdetc_side_t        date_side;
  logic               days_v;
  tdetc_days_t        days_q;
  tdetc_side_t        days_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_off_r <= ZONE_OFFSET_RESET;
    end else if (cfg_wr_en) begin
      zone_off_r <= cfg_wr_data;
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  tdetc_date_split u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .in_item  (in_item),
    .out_v    (date_v),
    .out_date (date_q),
    .out_side (date_side)
  );

  tdetc_civil_days u_civil (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (date_v),
    .in_date  (date_q),
    .in_side  (date_side),
    .out_v    (days_v),
    .out_days (days_q),
    .out_side (days_side)
  );

  tdetc_time_check u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (days_v),
    .in_days  (days_q),
    .in_side  (days_side),
    .zone_off (zone_off_r),
    .out_v    (out_valid),
    .out_item (out_item)
  );

  a_cfg_load : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (zone_off_r == $past(cfg_wr_data)))
    else $error("zone offset write not taken");

endmodule
